/* hw/rtl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the RTSP message framer
// Item structs for the byte and verdict channels, verdict codes, limits and
// the character table used when matching the length header name.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam logic [15:0] MAX_BUFFER_BYTES = 16'd65535;
    localparam logic [15:0] LEN_SAT          = 16'hFFFF;
    localparam logic [3:0]  TOKEN_LEN        = 4'd14;
    localparam logic [15:0] INTER_HDR_LEN    = 16'd4;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        ST_INCOMPLETE  = 2'd0,
        ST_REQUEST     = 2'd1,
        ST_INTERLEAVED = 2'd2,
        ST_MALFORMED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] header_len;
        logic [15:0] payload_len;
    } verdict_item_t;

    // handshake between the input stage and the scanner
    typedef struct packed {
        logic       take;
        byte_item_t item;
    } scan_req_t;

    // lower-case letters of the length header name, by position
    function automatic logic [7:0] token_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'hFF;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/rtsp_message_framer.sv */
// ----------------------------------------------------------------------------
// rtsp_message_framer: completeness check of an RTSP receive buffer
// Takes the bytes of a receive buffer one item per cycle, from its start, and
// gives one verdict item after the byte marked end_of_buffer: incomplete,
// request complete (header and payload lengths), interleaved frame complete
// (header 4, payload length) or malformed. Each byte passes from an input
// register through the scan state machine into a result register, and a new
// byte can be taken in every cycle; the verdict is loaded into the result
// register as its last byte leaves the input register. Only while a verdict
// waits under stall is a further end-of-buffer byte held back. The state
// restarts for a new buffer straight after each verdict. Buffers longer than
// MAX_BYTES (65535 by default) are reported as malformed.
// ----------------------------------------------------------------------------
module rtsp_message_framer #(
    parameter logic [15:0] MAX_BYTES = rmf_pkg::MAX_BUFFER_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  rmf_pkg::byte_item_t    byte_item,
    output logic                   verdict_valid,
    input  logic                   verdict_stall,
    output rmf_pkg::verdict_item_t verdict_item
);
    import rmf_pkg::*;

    logic          held_valid;
    byte_item_t    held_item;
    logic          out_busy;
    scan_req_t     req;
    logic          verdict_load;
    verdict_item_t verdict;

    rmf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .take       (req.take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // hold a closing byte while the previous verdict is still stalled
    assign req.take = held_valid && !(held_item.end_of_buffer && out_busy);
    assign req.item = held_item;

    rmf_scanner #(
        .MAX_BYTES (MAX_BYTES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .verdict_load (verdict_load),
        .verdict      (verdict)
    );

    rmf_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (verdict_load),
        .load_item     (verdict),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_item  (verdict_item),
        .busy          (out_busy)
    );

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> held_valid)
        else $error("input stalled with no held item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict_stall) |-> !verdict_load)
        else $error("verdict overwritten while stalled");

    a_empty_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && (verdict_item.status == ST_INCOMPLETE ||
                           verdict_item.status == ST_MALFORMED))
        |-> (verdict_item.header_len == 16'd0 && verdict_item.payload_len == 16'd0))
        else $error("lengths set on a failed verdict");

    a_inter_header: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict_item.status == ST_INTERLEAVED)
        |-> verdict_item.header_len == INTER_HDR_LEN)
        else $error("interleaved header length not four");

endmodule

/* hw/rtl/rmf_in_stage.sv */
// ----------------------------------------------------------------------------
// rmf_in_stage: input register of the framer
// Holds one incoming byte item until the scanner takes it.
// ----------------------------------------------------------------------------
module rmf_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  rmf_pkg::byte_item_t byte_item,
    input  logic               take,
    output logic               held_valid,
    output rmf_pkg::byte_item_t held_item
);
    import rmf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       accept;

    // stall only while a held item cannot leave this cycle
    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= byte_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

/* hw/rtl/rmf_scanner.sv */
// ----------------------------------------------------------------------------
// rmf_scanner: per-byte framing state machine
// Advances the scan state by one byte per take and forms the verdict on the
// byte that ends the buffer, then returns to the start of a fresh buffer.
// ----------------------------------------------------------------------------
module rmf_scanner #(
    parameter logic [15:0] MAX_BYTES = rmf_pkg::MAX_BUFFER_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rmf_pkg::scan_req_t     req,
    output logic                   verdict_load,
    output rmf_pkg::verdict_item_t verdict
);
    import rmf_pkg::*;

    typedef enum logic [10:0] {
        PH_START  = 11'b000_0000_0001,
        PH_LINE   = 11'b000_0000_0010,
        PH_TOKEN  = 11'b000_0000_0100,
        PH_SKIP   = 11'b000_0000_1000,
        PH_DIGITS = 11'b000_0001_0000,
        PH_REGION = 11'b000_0010_0000,
        PH_BODY   = 11'b000_0100_0000,
        PH_DONE   = 11'b000_1000_0000,
        PH_STOP   = 11'b001_0000_0000,
        PH_INTER  = 11'b010_0000_0000,
        PH_ERROR  = 11'b100_0000_0000
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [15:0] pos_reg,     pos_next;
    logic [1:0]  term_reg,    term_next;
    logic [7:0]  first_reg,   first_next;
    logic [7:0]  second_reg,  second_next;
    logic [3:0]  tok_reg,     tok_next;
    logic        seen_reg,    seen_next;
    logic [15:0] decl_reg,    decl_next;
    logic [15:0] hdr_reg,     hdr_next;
    logic [15:0] body_reg,    body_next;

    logic [7:0]  b;
    logic        last;
    logic        is_eol;
    logic        is_digit;
    logic        do_line;
    logic        do_done;
    logic        do_body;
    logic        ends_now;
    logic        ends_after;
    logic [19:0] dec_acc;
    logic [16:0] body_inc;

    assign b        = req.item.data_byte;
    assign last     = req.take && req.item.end_of_buffer;
    assign is_eol   = (b == CH_CR) || (b == CH_LF);
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign ends_now = (term_reg == 2'd3) || (term_reg == 2'd2 && second_reg == first_reg);
    // decimal accumulate: times ten as two shifts
    assign dec_acc  = {1'b0, decl_reg, 3'b000} + {3'b000, decl_reg, 1'b0}
                      + {12'd0, b - CH_ZERO};

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        term_next   = term_reg;
        first_next  = first_reg;
        second_next = second_reg;
        tok_next    = tok_reg;
        seen_next   = seen_reg;
        decl_next   = decl_reg;
        hdr_next    = hdr_reg;
        body_next   = body_reg;
        do_line     = 1'b0;
        do_done     = 1'b0;
        do_body     = 1'b0;
        body_inc    = 17'd0;

        if (req.take && phase_reg != PH_ERROR)
        begin
            if (pos_reg >= MAX_BYTES)
            begin
                phase_next = PH_ERROR;
            end
            else
            begin
                pos_next = pos_reg + 16'd1;
                case (phase_reg)
                    PH_START:
                    begin
                        if (b == CH_DOLLAR)
                        begin
                            phase_next = PH_INTER;
                        end
                        else if (is_eol || b == CH_NUL)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_LINE;
                        end
                    end
                    PH_LINE:
                    begin
                        do_line = 1'b1;
                    end
                    PH_TOKEN:
                    begin
                        if (tok_reg < TOKEN_LEN && fold_case(b) == token_char(tok_reg))
                        begin
                            tok_next = tok_reg + 4'd1;
                            if (tok_reg + 4'd1 >= TOKEN_LEN)
                            begin
                                seen_next  = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            do_line = 1'b1;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (b == CH_COLON || b == CH_SPACE)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (is_digit)
                        begin
                            decl_next  = {8'd0, b - CH_ZERO};
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            decl_next = (dec_acc > {4'd0, LEN_SAT}) ? LEN_SAT : dec_acc[15:0];
                        end
                        else
                        begin
                            do_line = 1'b1;
                        end
                    end
                    PH_REGION:
                    begin
                        if (is_eol)
                        begin
                            if (term_reg != 2'd3)
                            begin
                                term_next = term_reg + 2'd1;
                            end
                            if (second_reg == CH_NUL)
                            begin
                                second_next = b;
                            end
                        end
                        else if (term_reg != 2'd3 && (b == CH_SPACE || b == CH_TAB))
                        begin
                            if (second_reg == CH_NUL)
                            begin
                                second_next = b;
                            end
                        end
                        else if (ends_now)
                        begin
                            hdr_next  = pos_reg;
                            body_next = 16'd0;
                            if (decl_reg == 16'd0)
                            begin
                                phase_next = PH_DONE;
                                do_done    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                                do_body    = 1'b1;
                            end
                        end
                        else if (!seen_reg && fold_case(b) == token_char(4'd0))
                        begin
                            phase_next = PH_TOKEN;
                            tok_next   = 4'd1;
                        end
                        else if (b == CH_NUL)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_LINE;
                        end
                    end
                    PH_BODY:
                    begin
                        do_body = 1'b1;
                    end
                    PH_DONE:
                    begin
                        do_done = 1'b1;
                    end
                    PH_INTER:
                    begin
                        if (pos_reg == 16'd2)
                        begin
                            decl_next = {b, 8'd0};
                        end
                        else if (pos_reg == 16'd3)
                        begin
                            decl_next = {decl_reg[15:8], b};
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                // byte inside a text line
                if (do_line)
                begin
                    if (is_eol)
                    begin
                        phase_next  = PH_REGION;
                        term_next   = 2'd1;
                        first_next  = b;
                        second_next = CH_NUL;
                    end
                    else if (b == CH_NUL)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_LINE;
                    end
                end

                // count trailing NULs, stop on anything else
                if (do_done)
                begin
                    if (b == CH_NUL)
                    begin
                        if (body_next != LEN_SAT)
                        begin
                            body_next = body_next + 16'd1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end

                if (do_body)
                begin
                    body_inc  = {1'b0, body_next} + 17'd1;
                    body_next = body_inc[15:0];
                    if (body_inc >= {1'b0, decl_next})
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    assign ends_after = (term_next == 2'd3) ||
                        (term_next == 2'd2 && second_next == first_next);

    always_comb
    begin
        verdict.status      = ST_INCOMPLETE;
        verdict.header_len  = 16'd0;
        verdict.payload_len = 16'd0;
        case (phase_next)
            PH_ERROR:
            begin
                verdict.status = ST_MALFORMED;
            end
            PH_DONE, PH_STOP:
            begin
                verdict.status      = ST_REQUEST;
                verdict.header_len  = hdr_next;
                verdict.payload_len = body_next;
            end
            PH_REGION:
            begin
                if (ends_after && decl_next == 16'd0)
                begin
                    verdict.status     = ST_REQUEST;
                    verdict.header_len = pos_next;
                end
            end
            PH_INTER:
            begin
                if (pos_next >= INTER_HDR_LEN && (pos_next - INTER_HDR_LEN) >= decl_next)
                begin
                    verdict.status      = ST_INTERLEAVED;
                    verdict.header_len  = INTER_HDR_LEN;
                    verdict.payload_len = decl_next;
                end
            end
            default:
            begin
                verdict.status = ST_INCOMPLETE;
            end
        endcase
    end

    assign verdict_load = last;

    // restart from a fresh buffer once the verdict is out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            pos_reg    <= 16'd0;
            term_reg   <= 2'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            tok_reg    <= 4'd0;
            seen_reg   <= 1'b0;
            decl_reg   <= 16'd0;
            hdr_reg    <= 16'd0;
            body_reg   <= 16'd0;
        end
        else if (last)
        begin
            phase_reg  <= PH_START;
            pos_reg    <= 16'd0;
            term_reg   <= 2'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            tok_reg    <= 4'd0;
            seen_reg   <= 1'b0;
            decl_reg   <= 16'd0;
            hdr_reg    <= 16'd0;
            body_reg   <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            term_reg   <= term_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            tok_reg    <= tok_next;
            seen_reg   <= seen_next;
            decl_reg   <= decl_next;
            hdr_reg    <= hdr_next;
            body_reg   <= body_next;
        end
    end

endmodule

/* hw/rtl/rmf_out_stage.sv */
// ----------------------------------------------------------------------------
// rmf_out_stage: verdict result register
// Holds a verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module rmf_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rmf_pkg::verdict_item_t load_item,
    output logic                   verdict_valid,
    input  logic                   verdict_stall,
    output rmf_pkg::verdict_item_t verdict_item,
    output logic                   busy
);
    import rmf_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    verdict_item_t item_reg;

    assign busy = valid_reg && verdict_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!verdict_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict_item  = item_reg;

endmodule
